// ===== hw/rtl/prl_pkg.sv =====
// Shared types, codes and sizes for the per-client rate limiter.
package prl_pkg;

  localparam int unsigned PrlMaxClients = 16;
  localparam int unsigned AddrWidth     = 32;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned VerdictWidth  = 2;
  localparam int unsigned SlotWidth     = 4;

  localparam logic [VerdictWidth-1:0] VerdictAccept  = 2'd0;
  localparam logic [VerdictWidth-1:0] VerdictLimited = 2'd1;
  localparam logic [VerdictWidth-1:0] VerdictFull    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TIME,
    ST_DECIDE,
    ST_OUT
  } prl_state_e;

endpackage

// ===== hw/rtl/prl_req_if.sv =====
// Request channel: client address and current time with valid/ready.
interface prl_req_if
  import prl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] source_address;
  logic [TimeWidth-1:0] now_seconds;

  modport source (output valid, source_address, now_seconds, input ready);
  modport sink   (input valid, source_address, now_seconds, output ready);
endinterface

// ===== hw/rtl/prl_rsp_if.sv =====
// Result channel: verdict and client slot with valid/ready.
interface prl_rsp_if
  import prl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [VerdictWidth-1:0] verdict;
  logic [SlotWidth-1:0]    entry_slot;

  modport source (output valid, verdict, entry_slot, input ready);
  modport sink   (input valid, verdict, entry_slot, output ready);
endinterface

// ===== hw/rtl/per_client_rate_limiter.sv =====
// Per-client rate limiter: one request at a time, sequential table scan.
// A match goes from the scan through ST_TIME and ST_DECIDE to ST_OUT, a new client from
// the scan through ST_DECIDE to ST_OUT, and a full table from the scan straight to ST_OUT.
// A new request is taken only in ST_IDLE, after the result is accepted; the scan reads keys
// one after another through the key memory read port. Reset empties the client table (fill
// count to zero, no clearing pass) and sets the minimum interval to one second.
module per_client_rate_limiter
  import prl_pkg::*;
#(
  parameter int unsigned MAX_CLIENTS = PrlMaxClients
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  prl_req_if.sink                  req,
  prl_rsp_if.source                rsp,
  input  logic                     cfg_we_i,
  input  logic [IntervalWidth-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned IdxW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

  // Client memories
  logic [AddrWidth-1:0] key_mem  [MAX_CLIENTS];
  logic [TimeWidth-1:0] time_mem [MAX_CLIENTS];

  prl_state_e               state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [CntW-1:0]          rd_idx_q, rd_idx_d;
  logic                     pend_q, pend_d;
  logic [IdxW-1:0]          pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]          slot_q, slot_d;
  logic                     is_new_q, is_new_d;
  logic [AddrWidth-1:0]     addr_q, addr_d;
  logic [TimeWidth-1:0]     now_q, now_d;
  logic [VerdictWidth-1:0]  verdict_q, verdict_d;
  logic [IntervalWidth-1:0] min_interval_q;
  logic [AddrWidth-1:0]     key_rd_q;
  logic [TimeWidth-1:0]     time_rd_q;

  logic                     key_re, key_we, time_re, time_we;
  logic [TimeWidth-1:0]     time_wdata;
  logic [TimeWidth-1:0]     last_time;
  logic [TimeWidth-1:0]     diff;
  logic                     limited;
  logic                     hit;

  // Elapsed time check, shared compare
  assign last_time = is_new_q ? '0 : time_rd_q;
  assign diff      = now_q - last_time;
  assign limited   = diff[TimeWidth-1] ||
                     (diff < {{(TimeWidth-IntervalWidth){1'b0}}, min_interval_q});
  assign hit       = pend_q && (key_rd_q == addr_q);

  // Sequencer: next state and memory controls
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    slot_d     = slot_q;
    is_new_d   = is_new_q;
    addr_d     = addr_q;
    now_d      = now_q;
    verdict_d  = verdict_q;
    key_re     = 1'b0;
    key_we     = 1'b0;
    time_re    = 1'b0;
    time_we    = 1'b0;
    time_wdata = limited ? '0 : now_q;
    req.ready  = 1'b0;
    rsp.valid  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          addr_d   = req.source_address;
          now_d    = req.now_seconds;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Known client: fetch its last accepted time
          slot_d   = pend_idx_q;
          is_new_d = 1'b0;
          pend_d   = 1'b0;
          state_d  = ST_TIME;
        end else if (rd_idx_q < count_q) begin
          // Advance the scan by one key
          key_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IdxW-1:0];
          rd_idx_d   = rd_idx_q + CntW'(1);
        end else begin
          pend_d = 1'b0;
          if (count_q == CntW'(MAX_CLIENTS)) begin
            // Table full: drop the request
            verdict_d = VerdictFull;
            slot_d    = '0;
            state_d   = ST_OUT;
          end else begin
            // New client takes the next free slot
            key_we   = 1'b1;
            slot_d   = count_q[IdxW-1:0];
            count_d  = count_q + CntW'(1);
            is_new_d = 1'b1;
            state_d  = ST_DECIDE;
          end
        end
      end
      ST_TIME: begin
        time_re = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        time_we   = is_new_q || !limited;
        verdict_d = limited ? VerdictLimited : VerdictAccept;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        rsp.valid = 1'b1;
        if (rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp.verdict    = verdict_q;
  assign rsp.entry_slot = SlotWidth'(slot_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      rd_idx_q       <= '0;
      pend_q         <= 1'b0;
      min_interval_q <= IntervalWidth'(1);
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        min_interval_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
    is_new_q   <= is_new_d;
    addr_q     <= addr_d;
    now_q      <= now_d;
    verdict_q  <= verdict_d;
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[count_q[IdxW-1:0]] <= addr_q;
    end
    if (key_re) begin
      key_rd_q <= key_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  // Time memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (time_we) begin
      time_mem[slot_q] <= time_wdata;
    end
    if (time_re) begin
      time_rd_q <= time_mem[slot_q];
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the per-client rate limiter: verdict prediction and scoreboard.
`timescale 1ns / 100ps

module tb;
  import prl_pkg::*;

  localparam int unsigned ClkHalfPeriod = 5;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned SettleCycles  = PrlMaxClients + 12;
  localparam int unsigned StallCycles   = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 287;
  localparam int unsigned IdlePercent   = 25;

  // One expected result: verdict and reported slot
  typedef struct packed {
    logic [VerdictWidth-1:0] verdict;
    logic [SlotWidth-1:0]    slot;
  } verdict_rec_t;

  // Client table mirror, verdict prediction and result checking
  class verdict_tracker;
    logic [AddrWidth-1:0]     keys [PrlMaxClients];
    logic [TimeWidth-1:0]     last_times [PrlMaxClients];
    int unsigned              in_use;
    logic [IntervalWidth-1:0] min_interval;
    verdict_rec_t             pending_verdicts [$];
    int unsigned              errors;

    function new();
      for (int i = 0; i < PrlMaxClients; i++) begin
        keys[i]       = '0;
        last_times[i] = '0;
      end
      in_use       = 0;
      min_interval = 16'd1;
      errors       = 0;
    endfunction

    function void set_interval(logic [IntervalWidth-1:0] value);
      min_interval = value;
    endfunction

    function int unsigned pending_count();
      return pending_verdicts.size();
    endfunction

    // Look up the client, apply the minimum-interval rule and update the table
    function verdict_rec_t predict_verdict(logic [AddrWidth-1:0] addr,
                                           logic [TimeWidth-1:0] now);
      verdict_rec_t         rec;
      int unsigned          slot;
      bit                   found;
      bit                   limited;
      logic [TimeWidth-1:0] diff;
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < in_use; i++) begin
        if (!found && keys[i] == addr) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (in_use >= PrlMaxClients) begin
          rec.verdict = VerdictFull;
          rec.slot    = '0;
          return rec;
        end
        slot             = in_use;
        in_use++;
        keys[slot]       = addr;
        last_times[slot] = '0;
      end
      diff    = now - last_times[slot];
      limited = diff[TimeWidth-1] || (diff < {16'd0, min_interval});
      if (!limited) last_times[slot] = now;
      rec.verdict = limited ? VerdictLimited : VerdictAccept;
      rec.slot    = slot[SlotWidth-1:0];
      return rec;
    endfunction

    function void note_request(logic [AddrWidth-1:0] addr, logic [TimeWidth-1:0] now);
      pending_verdicts.push_back(predict_verdict(addr, now));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Compare a result against the oldest prediction, field by field
    task check_result(logic [VerdictWidth-1:0] verdict, logic [SlotWidth-1:0] slot);
      verdict_rec_t exp_rec;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with no request outstanding",
                                  verdict, slot));
      end else begin
        exp_rec = pending_verdicts.pop_front();
        if (verdict !== exp_rec.verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d", verdict, exp_rec.verdict));
        if (slot !== exp_rec.slot)
          report_mismatch($sformatf("entry_slot %0d, predicted %0d", slot, exp_rec.slot));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [IntervalWidth-1:0] cfg_wdata;
  bit                       quiet_mode;
  bit                       stall_results_req;
  int unsigned              idle_cycles;
  verdict_tracker           sb;

  prl_req_if req_if ();
  prl_rsp_if rsp_if ();

  per_client_rate_limiter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock
  always #(ClkHalfPeriod) clk_i = ~clk_i;

  // Known values on every input from time zero
  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_if.valid       = 1'b0;
    req_if.source_address = '0;
    req_if.now_seconds = '0;
    rsp_if.ready       = 1'b0;
    quiet_mode         = 1'b0;
    stall_results_req  = 1'b0;
    idle_cycles        = 0;
    sb                 = new();
  end

  // Sample handshakes and register writes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.set_interval(cfg_wdata);
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.source_address, req_if.now_seconds);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.verdict, rsp_if.entry_slot);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_results_req) begin
        stall_results_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (StallCycles - 1) begin
          @(negedge clk_i);
          rsp_if.ready <= 1'b0;
        end
      end else if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (quiet_mode) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Offer one request, idling first at random; returns at the falling edge after acceptance
  task automatic send_request(input logic [AddrWidth-1:0] addr,
                              input logic [TimeWidth-1:0] now);
    while (!quiet_mode && $urandom_range(99) < IdlePercent) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.source_address <= addr;
    req_if.now_seconds    <= now;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Hold the request side and wait for every outstanding result
  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_min_interval(input logic [IntervalWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random traffic over the known clients, with noise, backward times and unknown clients
  task automatic run_phase(input logic [IntervalWidth-1:0] interval, input bit stall_rx);
    logic [TimeWidth-1:0] wall_now;
    logic [AddrWidth-1:0] addr;
    logic [TimeWidth-1:0] now;
    int unsigned          step_max;
    int unsigned          pick;
    write_min_interval(interval);
    step_max = interval / 8 + 1;
    wall_now = $urandom;
    for (int n = 0; n < PhaseItems; n++) begin
      if (stall_rx && n == 20) stall_results_req = 1'b1;
      pick     = $urandom_range(99);
      addr     = sb.keys[$urandom_range(sb.in_use - 1)];
      wall_now = wall_now + $urandom_range(step_max);
      if (pick < 80) begin
        now = wall_now;
      end else if (pick < 88) begin
        now = $urandom;
      end else if (pick < 95) begin
        now = wall_now - $urandom_range(100, 1);
      end else begin
        addr = $urandom;
        now  = wall_now;
      end
      send_request(addr, now);
    end
    settle();
  endtask

  // Main sequence
  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // New client below the minimum, accept, repeat, time going backwards
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0000);
    // New client with negative signed time, then the largest signed gaps
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the table, then refuse an unknown client
    for (int i = 2; i < PrlMaxClients; i++)
      send_request($urandom, $urandom_range(1000, 1));
    send_request(32'hA5A5_5A5A, 32'h0000_1000);
    settle();

    // Minimum of zero: equal time accepted, backwards still limited
    write_min_interval(16'd0);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0000);
    settle();

    // Largest minimum: exactly on the boundary, then one short of it
    write_min_interval(16'hFFFF);
    send_request(32'h0000_0000, 32'h0001_0000);
    send_request(32'h0000_0000, 32'h0001_FFFE);
    settle();

    run_phase(16'd0, 1'b0);
    run_phase(16'hFFFF, 1'b1);
    run_phase(16'($urandom_range(20, 2)), 1'b0);
    quiet_mode = 1'b1;
    run_phase(16'($urandom), 1'b0);
    quiet_mode = 1'b0;
    run_phase(16'($urandom), 1'b0);
    run_phase(16'd1, 1'b0);

    if (sb.errors == 0 && sb.pending_count() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
